// ===== rtl/core/dtoi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal text to int32 package
// Shared types and constants: beat classes, queue entry, parser phases.
// ----------------------------------------------------------------------------
package dtoi_pkg;

	// Default number of entries in the queue between front and back.
	localparam int unsigned DTOI_QUEUE_DEPTH = 4;

	// Magnitude limits for positive and negative results.
	localparam logic [31:0] DTOI_MAX_POS = 32'd2147483647;
	localparam logic [31:0] DTOI_MAX_NEG = 32'd2147483648;

	// Character codes that the front looks at.
	localparam logic [7:0] CHR_TAB   = 8'd9;
	localparam logic [7:0] CHR_CR    = 8'd13;
	localparam logic [7:0] CHR_SPACE = 8'd32;
	localparam logic [7:0] CHR_PLUS  = 8'd43;
	localparam logic [7:0] CHR_MINUS = 8'd45;
	localparam logic [7:0] CHR_ZERO  = 8'd48;
	localparam logic [7:0] CHR_NINE  = 8'd57;

	// Class of one beat, decided by the front.
	typedef enum logic [2:0] {
		CLS_SPACE = 3'd0,
		CLS_SIGN  = 3'd1,
		CLS_DIGIT = 3'd2,
		CLS_OTHER = 3'd3,
		CLS_END   = 3'd4
	} dtoi_class_t;

	// One classified beat as it travels through the queue.
	typedef struct packed {
		dtoi_class_t cls;
		logic        neg;    // sign beat carries a minus
		logic [3:0]  digit;  // digit value for digit beats
	} dtoi_beat_t;

	// Head of the queue as seen by the back.
	typedef struct packed {
		logic       valid;
		dtoi_beat_t beat;
	} dtoi_head_t;

	// Parser phase, one-hot.
	typedef enum logic [2:0] {
		PH_SPACE  = 3'b001,
		PH_SIGN   = 3'b010,
		PH_DIGITS = 3'b100
	} dtoi_phase_t;

endpackage
`default_nettype wire

// ===== rtl/core/decimal_text_to_int32_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal text to int32 unit
// Converts a stream of decimal characters into a checked signed 32-bit value.
// ----------------------------------------------------------------------------
// Usage: the character channel (char_valid, char_stall, char_code,
// end_of_string) takes one character per beat, and a beat with end_of_string
// set closes the string. The result channel (result_valid, result_stall,
// value, parse_error) gives one beat for each closed string.
// Leading whitespace, one optional sign and then digits are accepted; any other
// pattern or a value outside the signed 32-bit range gives parse_error with a
// value of zero. An empty string gives zero with no error.
// Throughput is one beat per cycle on the character channel while char_stall
// is low. The back part updates the magnitude with one multiply-by-ten and add
// per cycle, which is what sets that rate.
// A closing beat is first written into the queue; once it reaches the head and
// the back pops it, its result is loaded into the result register.
// After reset the queue is empty, the parser is at the start of a string and
// no result is pending. While the receiver stalls, the result holds steady and
// character beats keep being parsed until the next closing beat reaches the
// head of the queue; once the queue fills, char_stall rises.
// ----------------------------------------------------------------------------
module decimal_text_to_int32_unit #(
	parameter int unsigned QUEUE_DEPTH = dtoi_pkg::DTOI_QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          char_valid,
	output logic               char_stall,
	input  wire logic [7:0]    char_code,
	input  wire logic          end_of_string,
	output logic               result_valid,
	input  wire logic          result_stall,
	output logic signed [31:0] value,
	output logic               parse_error
);
	import dtoi_pkg::*;

	// Classified beat from the front, pushed when the queue has room.
	dtoi_beat_t front_beat;
	logic       front_push;
	logic       queue_full;

	// Head of the queue and the pop taken by the back.
	dtoi_head_t queue_head;
	logic       back_pop;

	dtoi_front u_front (
		.char_valid    (char_valid),
		.char_stall    (char_stall),
		.char_code     (char_code),
		.end_of_string (end_of_string),
		.queue_full    (queue_full),
		.push          (front_push),
		.beat          (front_beat)
	);

	dtoi_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_push),
		.beat   (front_beat),
		.full   (queue_full),
		.pop    (back_pop),
		.head   (queue_head)
	);

	// The back owns the parser state and the result register.
	dtoi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (queue_head),
		.pop          (back_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.parse_error  (parse_error)
	);

`ifndef SYNTH
	// A reported error always carries a zero value.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && parse_error) |-> (value == 32'sd0))
		else $error("error result with nonzero value");

	// A closing beat leaves the queue only when the result slot can take it.
	a_end_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(back_pop && (queue_head.beat.cls == CLS_END)) |->
		(!result_valid || !result_stall))
		else $error("closing beat popped over a pending result");

	// An accepted beat is in the queue at the next cycle.
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !char_stall) |=> queue_head.valid)
		else $error("accepted beat missing from queue");

	// The back never pops an empty queue.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		back_pop |-> queue_head.valid)
		else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/dtoi_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal text to int32 front
// Accepts character beats and classifies them for the queue.
// ----------------------------------------------------------------------------
module dtoi_front (
	input  wire logic             char_valid,
	output logic                  char_stall,
	input  wire logic [7:0]       char_code,
	input  wire logic             end_of_string,
	input  wire logic             queue_full,
	output logic                  push,
	output dtoi_pkg::dtoi_beat_t  beat
);
	import dtoi_pkg::*;

	logic is_space;
	logic is_sign;
	logic is_digit;

	assign char_stall = queue_full;
	assign push       = char_valid && !queue_full;

	assign is_space = ((char_code >= CHR_TAB) && (char_code <= CHR_CR)) ||
		(char_code == CHR_SPACE);
	assign is_sign  = (char_code == CHR_PLUS) || (char_code == CHR_MINUS);
	assign is_digit = (char_code >= CHR_ZERO) && (char_code <= CHR_NINE);

	always_comb begin
		beat.neg   = (char_code == CHR_MINUS);
		beat.digit = is_digit ? 4'(char_code - CHR_ZERO) : 4'd0;
		priority if (end_of_string) begin
			beat.cls = CLS_END;
		end else if (is_space) begin
			beat.cls = CLS_SPACE;
		end else if (is_sign) begin
			beat.cls = CLS_SIGN;
		end else if (is_digit) begin
			beat.cls = CLS_DIGIT;
		end else begin
			beat.cls = CLS_OTHER;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/dtoi_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal text to int32 queue
// Small first-in first-out buffer of classified beats.
// ----------------------------------------------------------------------------
module dtoi_queue #(
	parameter int unsigned DEPTH = dtoi_pkg::DTOI_QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire dtoi_pkg::dtoi_beat_t beat,
	output logic                      full,
	input  wire logic                 pop,
	output dtoi_pkg::dtoi_head_t      head
);
	import dtoi_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	dtoi_beat_t       entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.beat  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/dtoi_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal text to int32 back
// Runs the parser state on classified beats and holds the result register.
// ----------------------------------------------------------------------------
module dtoi_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dtoi_pkg::dtoi_head_t head,
	output logic                      pop,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic signed [31:0]        value,
	output logic                      parse_error
);
	import dtoi_pkg::*;

	dtoi_phase_t phase_q;
	logic        neg_q;
	logic [31:0] mag_q;
	logic        err_q;

	logic        result_valid_q;
	logic [31:0] value_q;
	logic        parse_error_q;

	logic        slot_free;
	logic        is_end;
	logic [34:0] next_mag;
	logic [34:0] limit;
	logic        over;
	logic        end_err;

	assign slot_free = !result_valid_q || !result_stall;
	assign is_end    = (head.beat.cls == CLS_END);
	assign pop       = head.valid && (!is_end || slot_free);

	// Multiply by ten as two shifted copies, then add the digit.
	assign next_mag = ({3'b000, mag_q} << 3) + ({3'b000, mag_q} << 1) +
		35'(head.beat.digit);
	assign limit    = {3'b000, neg_q ? DTOI_MAX_NEG : DTOI_MAX_POS};
	assign over     = (next_mag > limit);
	assign end_err  = err_q || (phase_q == PH_SIGN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			err_q   <= 1'b0;
		end else if (pop) begin
			if (is_end) begin
				phase_q <= PH_SPACE;
				neg_q   <= 1'b0;
				mag_q   <= '0;
				err_q   <= 1'b0;
			end else if (!err_q) begin
				unique case (head.beat.cls)
					CLS_SPACE: begin
						if (phase_q != PH_SPACE) begin
							err_q <= 1'b1;
						end
					end
					CLS_SIGN: begin
						if (phase_q == PH_SPACE) begin
							neg_q   <= head.beat.neg;
							phase_q <= PH_SIGN;
						end else begin
							err_q <= 1'b1;
						end
					end
					CLS_DIGIT: begin
						if (over) begin
							err_q <= 1'b1;
						end else begin
							mag_q   <= next_mag[31:0];
							phase_q <= PH_DIGITS;
						end
					end
					default: begin
						err_q <= 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (pop && is_end) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && is_end) begin
			parse_error_q <= end_err;
			if (end_err) begin
				value_q <= '0;
			end else begin
				value_q <= neg_q ? 32'(32'd0 - mag_q) : mag_q;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign parse_error  = parse_error_q;

endmodule
`default_nettype wire
